/* sv/spi_nor_flash_command_sequencer_assert.svh */
// Assertion macros for the flash command sequencer.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// Implication checked every clock, disabled in reset.
`define SNF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/snfcs_pkg.sv */
`timescale 1ns / 1ps
package snfcs_pkg;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int BLOCK_BYTES  = 65536;
  localparam int ADDR_BITS    = 24;
  localparam int ADDR_BYTES   = (ADDR_BITS + 7) / 8;
  localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
  localparam int SECTOR_BITS  = $clog2(SECTOR_BYTES);
  localparam int BLOCK_BITS   = $clog2(BLOCK_BYTES);
  localparam int MAX_RES      = 4;

  localparam logic [2:0] F_PROBE = 3'd0;
  localparam logic [2:0] F_READ  = 3'd1;
  localparam logic [2:0] F_WRITE = 3'd2;
  localparam logic [2:0] F_ESEC  = 3'd3;
  localparam logic [2:0] F_EBLK  = 3'd4;
  localparam logic [2:0] F_HOST  = 3'd5;
  localparam logic [2:0] F_REPLY = 3'd6;
  localparam logic [2:0] F_TICK  = 3'd7;

  localparam logic [2:0] K_SEND = 3'd0;
  localparam logic [2:0] K_REL  = 3'd1;
  localparam logic [2:0] K_DATA = 3'd2;
  localparam logic [2:0] K_DONE = 3'd3;
  localparam logic [2:0] K_KICK = 3'd4;
  localparam logic [2:0] K_HOST = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NRDY    = 3'd1;
  localparam logic [2:0] ST_BADARG  = 3'd2;
  localparam logic [2:0] ST_WEFAIL  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_IDBAD   = 3'd5;

  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PROG  = 8'h02;
  localparam logic [7:0] CMD_ESEC  = 8'h20;
  localparam logic [7:0] CMD_EBLK  = 8'hD8;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_JEDEC = 8'h9F;
  localparam logic [7:0] ID0       = 8'hEF;
  localparam logic [7:0] ID1       = 8'h40;
  localparam logic [7:0] ID2       = 8'h18;
  localparam logic [7:0] DUMMY     = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b00000000001,
    PH_ID      = 11'b00000000010,
    PH_HDR     = 11'b00000000100,
    PH_RDATA   = 11'b00000001000,
    PH_WE      = 11'b00000010000,
    PH_RS_CMD  = 11'b00000100000,
    PH_RS_DATA = 11'b00001000000,
    PH_HOSTW   = 11'b00010000000,
    PH_PDATA   = 11'b00100000000,
    PH_BZ_CMD  = 11'b01000000000,
    PH_BZ_DATA = 11'b10000000000
  } phase_t;

  // packed from the top down: kind ends up in the low bits
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic [2:0] kind;
  } res_t;

endpackage

/* sv/spi_nor_flash_command_sequencer.sv */
`timescale 1ns / 1ps
// SPI NOR flash command sequencer. Each accepted event (request, host byte,
// SPI reply byte or millisecond tick) is handled by the combinational phase
// logic and yields up to three result items. Results queue in a result buffer
// of eight entries; an event is taken in any clock in which at least four
// slots are free, so back-to-back events go through without a gap as long
// as the output drains as fast as results are made. The output moves one
// result per clock while m_tready is high, so a run of events that each
// make two or three results fills the buffer and then holds the input
// until the backlog drains. A result with kind 0 is one byte exchange:
// the next serial event must be the reply byte (func 6).
module spi_nor_flash_command_sequencer import snfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // func[2:0], address[26:3], length[51:27], data_byte[59:52]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // kind[2:0], out_byte[10:3], status[13:11]
  output logic        m_tlast
);

  localparam int QD = 8;

  logic [15:0] busy_timeout_ms;
  phase_t phase, phase_next;
  logic [2:0]  current_op, current_op_next;
  logic        ready_flag, ready_flag_next;
  logic [ADDR_BITS-1:0] cur_address, cur_address_next;
  logic [24:0] bytes_left, bytes_left_next;
  logic [PAGE_BITS:0] chunk_left, chunk_left_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic        id_bad, id_bad_next;

  logic [2:0]  func;
  logic [23:0] address;
  logic [24:0] length;
  logic [7:0]  data_byte;
  assign func      = s_tdata[2:0];
  assign address   = s_tdata[26:3];
  assign length    = s_tdata[51:27];
  assign data_byte = s_tdata[59:52];

  res_t res [MAX_RES];
  logic [2:0] nres;

  res_t q_data [QD];
  logic       q_last [QD];
  logic [2:0] wp, rp;
  logic [3:0] cnt;
  logic       acc, pop;

  assign s_tready = (cnt <= 4'(QD - MAX_RES));
  assign acc = s_tvalid && s_tready;
  assign m_tvalid = (cnt != 4'd0);
  assign pop = m_tvalid && m_tready;
  assign m_tdata = {2'b00, q_data[rp]};
  assign m_tlast = q_last[rp];

  function automatic res_t mk(input logic [2:0] k, input logic [7:0] b, input logic [2:0] s);
    res_t r;
    r.kind = k;
    r.out_byte = b;
    r.status = s;
    return r;
  endfunction

  logic [7:0] id_exp;
  logic [PAGE_BITS:0] room;
  logic [ADDR_BITS+7:0] addr_ext;

  always_comb begin
    phase_next = phase;
    current_op_next = current_op;
    ready_flag_next = ready_flag;
    cur_address_next = cur_address;
    bytes_left_next = bytes_left;
    chunk_left_next = chunk_left;
    byte_index_next = byte_index;
    elapsed_ms_next = elapsed_ms;
    id_bad_next = id_bad;
    nres = 3'd0;
    for (int i = 0; i < MAX_RES; i++) res[i] = mk(K_SEND, 8'h00, ST_OK);
    id_exp = ID0;
    room = '0;
    addr_ext = {8'h00, cur_address};
    case (func)
      F_PROBE, F_READ, F_WRITE, F_ESEC, F_EBLK: begin
        if (phase == PH_IDLE) begin
          nres = 3'd1;
          if (func == F_PROBE) begin
            current_op_next = F_PROBE;
            id_bad_next = 1'b0;
            phase_next = PH_ID;
            byte_index_next = 3'd0;
            res[0] = mk(K_SEND, CMD_JEDEC, ST_OK);
          end else if (!ready_flag) begin
            res[0] = mk(K_DONE, 8'h00, ST_NRDY);
          end else if (((func == F_READ) || (func == F_WRITE)) && (length == 25'd0)) begin
            res[0] = mk(K_DONE, 8'h00, ST_BADARG);
          end else if ((func == F_ESEC) && (address[SECTOR_BITS-1:0] != '0)) begin
            res[0] = mk(K_DONE, 8'h00, ST_BADARG);
          end else if ((func == F_EBLK) && (address[BLOCK_BITS-1:0] != '0)) begin
            res[0] = mk(K_DONE, 8'h00, ST_BADARG);
          end else begin
            current_op_next = func;
            cur_address_next = address[ADDR_BITS-1:0];
            bytes_left_next = length;
            chunk_left_next = '0;
            if (func == F_READ) begin
              phase_next = PH_HDR;
              byte_index_next = 3'd0;
              res[0] = mk(K_SEND, CMD_READ, ST_OK);
            end else begin
              phase_next = PH_WE;
              res[0] = mk(K_SEND, CMD_WREN, ST_OK);
            end
          end
        end
      end
      F_HOST: begin
        if (phase == PH_HOSTW) begin
          phase_next = PH_PDATA;
          nres = 3'd1;
          res[0] = mk(K_SEND, data_byte, ST_OK);
        end
      end
      F_TICK: begin
        if (((phase == PH_BZ_CMD) || (phase == PH_BZ_DATA)) && (elapsed_ms != 16'hFFFF))
          elapsed_ms_next = elapsed_ms + 16'd1;
      end
      default: begin
        case (phase)
          PH_ID: begin
            case (byte_index)
              3'd1: id_exp = ID0;
              3'd2: id_exp = ID1;
              default: id_exp = ID2;
            endcase
            if ((byte_index != 3'd0) && (data_byte != id_exp)) id_bad_next = 1'b1;
            if (byte_index < 3'd3) begin
              byte_index_next = byte_index + 3'd1;
              nres = 3'd1;
              res[0] = mk(K_SEND, DUMMY, ST_OK);
            end else begin
              nres = 3'd2;
              res[0] = mk(K_REL, 8'h00, ST_OK);
              phase_next = PH_IDLE;
              if (id_bad_next) res[1] = mk(K_DONE, 8'h00, ST_IDBAD);
              else begin
                ready_flag_next = 1'b1;
                res[1] = mk(K_DONE, 8'h00, ST_OK);
              end
            end
          end
          PH_HDR: begin
            if (byte_index < 3'(ADDR_BYTES)) begin
              byte_index_next = byte_index + 3'd1;
              nres = 3'd1;
              addr_ext = {8'h00, cur_address} >> (8 * (ADDR_BYTES - 1 - int'(byte_index)));
              res[0] = mk(K_SEND, addr_ext[7:0], ST_OK);
            end else if (current_op == F_READ) begin
              phase_next = PH_RDATA;
              nres = 3'd1;
              res[0] = mk(K_SEND, DUMMY, ST_OK);
            end else if (current_op == F_WRITE) begin
              phase_next = PH_HOSTW;
              nres = 3'd1;
              res[0] = mk(K_HOST, 8'h00, ST_OK);
            end else begin
              nres = 3'd2;
              res[0] = mk(K_REL, 8'h00, ST_OK);
              elapsed_ms_next = 16'd0;
              if (busy_timeout_ms == 16'd0) begin
                phase_next = PH_IDLE;
                res[1] = mk(K_DONE, 8'h00, ST_TIMEOUT);
              end else begin
                phase_next = PH_BZ_CMD;
                res[1] = mk(K_SEND, CMD_RDSR, ST_OK);
              end
            end
          end
          PH_RDATA: begin
            res[0] = mk(K_DATA, data_byte, ST_OK);
            if (bytes_left != 25'd0) bytes_left_next = bytes_left - 25'd1;
            if (bytes_left_next != 25'd0) begin
              nres = 3'd2;
              res[1] = mk(K_SEND, DUMMY, ST_OK);
            end else begin
              nres = 3'd3;
              res[1] = mk(K_REL, 8'h00, ST_OK);
              res[2] = mk(K_DONE, 8'h00, ST_OK);
              phase_next = PH_IDLE;
            end
          end
          PH_WE: begin
            nres = 3'd2;
            res[0] = mk(K_REL, 8'h00, ST_OK);
            res[1] = mk(K_SEND, CMD_RDSR, ST_OK);
            phase_next = PH_RS_CMD;
          end
          PH_RS_CMD: begin
            nres = 3'd1;
            res[0] = mk(K_SEND, DUMMY, ST_OK);
            phase_next = PH_RS_DATA;
          end
          PH_RS_DATA: begin
            nres = 3'd2;
            res[0] = mk(K_REL, 8'h00, ST_OK);
            if (!data_byte[1]) begin
              phase_next = PH_IDLE;
              res[1] = mk(K_DONE, 8'h00, ST_WEFAIL);
            end else begin
              phase_next = PH_HDR;
              byte_index_next = 3'd0;
              if (current_op == F_WRITE) begin
                room = (PAGE_BITS+1)'(PAGE_BYTES) - {1'b0, cur_address[PAGE_BITS-1:0]};
                if ({{(25-PAGE_BITS-1){1'b0}}, room} < bytes_left) chunk_left_next = room;
                else chunk_left_next = bytes_left[PAGE_BITS:0];
                res[1] = mk(K_SEND, CMD_PROG, ST_OK);
              end else if (current_op == F_ESEC) res[1] = mk(K_SEND, CMD_ESEC, ST_OK);
              else res[1] = mk(K_SEND, CMD_EBLK, ST_OK);
            end
          end
          PH_PDATA: begin
            if (chunk_left != '0) chunk_left_next = chunk_left - (PAGE_BITS+1)'(1);
            if (bytes_left != 25'd0) bytes_left_next = bytes_left - 25'd1;
            cur_address_next = cur_address + ADDR_BITS'(1);
            if (chunk_left_next != '0) begin
              phase_next = PH_HOSTW;
              nres = 3'd1;
              res[0] = mk(K_HOST, 8'h00, ST_OK);
            end else begin
              nres = 3'd2;
              res[0] = mk(K_REL, 8'h00, ST_OK);
              elapsed_ms_next = 16'd0;
              if (busy_timeout_ms == 16'd0) begin
                phase_next = PH_IDLE;
                res[1] = mk(K_DONE, 8'h00, ST_TIMEOUT);
              end else begin
                phase_next = PH_BZ_CMD;
                res[1] = mk(K_SEND, CMD_RDSR, ST_OK);
              end
            end
          end
          PH_BZ_CMD: begin
            nres = 3'd1;
            res[0] = mk(K_SEND, DUMMY, ST_OK);
            phase_next = PH_BZ_DATA;
          end
          PH_BZ_DATA: begin
            res[0] = mk(K_REL, 8'h00, ST_OK);
            if (!data_byte[0]) begin
              nres = 3'd2;
              if ((current_op == F_WRITE) && (bytes_left != 25'd0)) begin
                phase_next = PH_WE;
                res[1] = mk(K_SEND, CMD_WREN, ST_OK);
              end else begin
                phase_next = PH_IDLE;
                res[1] = mk(K_DONE, 8'h00, ST_OK);
              end
            end else begin
              nres = 3'd3;
              res[1] = mk(K_KICK, 8'h00, ST_OK);
              if (elapsed_ms < busy_timeout_ms) begin
                phase_next = PH_BZ_CMD;
                res[2] = mk(K_SEND, CMD_RDSR, ST_OK);
              end else begin
                phase_next = PH_IDLE;
                res[2] = mk(K_DONE, 8'h00, ST_TIMEOUT);
              end
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_timeout_ms <= TIMEOUT_RESET;
      phase <= PH_IDLE;
      current_op <= 3'd0;
      ready_flag <= 1'b0;
      cur_address <= '0;
      bytes_left <= '0;
      chunk_left <= '0;
      byte_index <= '0;
      elapsed_ms <= '0;
      id_bad <= 1'b0;
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (cfg_we) busy_timeout_ms <= cfg_wdata;
      if (acc) begin
        phase <= phase_next;
        current_op <= current_op_next;
        ready_flag <= ready_flag_next;
        cur_address <= cur_address_next;
        bytes_left <= bytes_left_next;
        chunk_left <= chunk_left_next;
        byte_index <= byte_index_next;
        elapsed_ms <= elapsed_ms_next;
        id_bad <= id_bad_next;
        wp <= wp + nres;
      end
      if (pop) rp <= rp + 3'd1;
      cnt <= cnt + (acc ? {1'b0, nres} : 4'd0) - (pop ? 4'd1 : 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (3'(i) < nres) begin
          q_data[wp + 3'(i)] <= res[i];
          q_last[wp + 3'(i)] <= (3'(i) == nres - 3'd1);
        end
      end
    end
  end

`include "spi_nor_flash_command_sequencer_assert.svh"

  `SNF_ASSERT_IMP(a_no_overflow, 1'b1, cnt <= 4'(QD), "result buffer overflow")
  `SNF_ASSERT_NEXT(a_ready_needs_probe, !ready_flag && !(acc && func == F_REPLY), !ready_flag, "ready without probe reply")
  `SNF_ASSERT_IMP(a_onehot_phase, 1'b1, $onehot(phase), "phase not one-hot")
  `SNF_ASSERT_IMP(a_chunk_bound, 1'b1, chunk_left <= (PAGE_BITS+1)'(PAGE_BYTES), "chunk exceeds page")

endmodule

/* sim/spi_nor_flash_command_sequencer_test.sv */
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_test;
  import snfcs_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ob;
    logic [2:0] st;
    logic       last;
  } flash_res_t;

  typedef struct {
    logic [2:0]  f;
    logic [23:0] a;
    logic [24:0] l;
    logic [7:0]  b;
    bit          chk;
    logic [2:0]  kind;
    logic [2:0]  st;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // func[2:0], address[26:3], length[51:27], data_byte[59:52]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // kind[2:0], out_byte[10:3], status[13:11]
  logic        m_tlast;

  spi_nor_flash_command_sequencer u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // shadow of the sequencer state
  phase_t      ph;
  logic [2:0]  cop;
  logic        rdy;
  logic [23:0] caddr;
  logic [24:0] bleft;
  logic [8:0]  cleft;
  logic [2:0]  bidx;
  logic [15:0] elap;
  logic        idbad;
  logic [15:0] tmo;

  flash_res_t flash_results_q[$];
  flash_res_t step_q[$];
  int  errors = 0;
  int  idle_cnt = 0;
  bit  calm = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void put(logic [2:0] k, logic [7:0] ob, logic [2:0] st);
    step_q.push_back('{kind: k, ob: ob, st: st, last: 1'b0});
  endfunction

  function automatic void finish_op(logic [2:0] st);
    ph = PH_IDLE;
    put(K_DONE, 8'h00, st);
  endfunction

  function automatic void start_busy();
    elap = '0;
    if (tmo == 0) begin
      finish_op(ST_TIMEOUT);
    end else begin
      ph = PH_BZ_CMD;
      put(K_SEND, CMD_RDSR, ST_OK);
    end
  endfunction

  function automatic void begin_header(logic [7:0] cmd);
    ph = PH_HDR;
    bidx = '0;
    put(K_SEND, cmd, ST_OK);
  endfunction

  function automatic void begin_wel();
    ph = PH_WE;
    put(K_SEND, CMD_WREN, ST_OK);
  endfunction

  function automatic void serial_reply(logic [7:0] b);
    logic [8:0] room;
    logic [7:0] id_want;
    case (ph)
      PH_ID: begin
        id_want = (bidx == 1) ? ID0 : (bidx == 2) ? ID1 : ID2;
        if (bidx >= 1 && b != id_want) idbad = 1'b1;
        if (bidx < 3) begin
          bidx++;
          put(K_SEND, DUMMY, ST_OK);
        end else begin
          put(K_REL, 8'h00, ST_OK);
          if (idbad) finish_op(ST_IDBAD);
          else begin
            rdy = 1'b1;
            finish_op(ST_OK);
          end
        end
      end
      PH_HDR: begin
        if (bidx < ADDR_BYTES) begin
          put(K_SEND, 8'(caddr >> (8 * (ADDR_BYTES - 1 - int'(bidx)))), ST_OK);
          bidx++;
        end else if (cop == F_READ) begin
          ph = PH_RDATA;
          put(K_SEND, DUMMY, ST_OK);
        end else if (cop == F_WRITE) begin
          ph = PH_HOSTW;
          put(K_HOST, 8'h00, ST_OK);
        end else begin
          put(K_REL, 8'h00, ST_OK);
          start_busy();
        end
      end
      PH_RDATA: begin
        put(K_DATA, b, ST_OK);
        if (bleft > 0) bleft--;
        if (bleft > 0) put(K_SEND, DUMMY, ST_OK);
        else begin
          put(K_REL, 8'h00, ST_OK);
          finish_op(ST_OK);
        end
      end
      PH_WE: begin
        put(K_REL, 8'h00, ST_OK);
        ph = PH_RS_CMD;
        put(K_SEND, CMD_RDSR, ST_OK);
      end
      PH_RS_CMD: begin
        ph = PH_RS_DATA;
        put(K_SEND, DUMMY, ST_OK);
      end
      PH_RS_DATA: begin
        put(K_REL, 8'h00, ST_OK);
        if (!b[1]) finish_op(ST_WEFAIL);
        else if (cop == F_WRITE) begin
          room = 9'd256 - {1'b0, caddr[7:0]};
          cleft = (room < bleft) ? room : bleft[8:0];
          begin_header(CMD_PROG);
        end else begin
          begin_header(cop == F_ESEC ? CMD_ESEC : CMD_EBLK);
        end
      end
      PH_PDATA: begin
        if (cleft > 0) cleft--;
        if (bleft > 0) bleft--;
        caddr = caddr + 24'd1;
        if (cleft > 0) begin
          ph = PH_HOSTW;
          put(K_HOST, 8'h00, ST_OK);
        end else begin
          put(K_REL, 8'h00, ST_OK);
          start_busy();
        end
      end
      PH_BZ_CMD: begin
        ph = PH_BZ_DATA;
        put(K_SEND, DUMMY, ST_OK);
      end
      PH_BZ_DATA: begin
        put(K_REL, 8'h00, ST_OK);
        if (!b[0]) begin
          if (cop == F_WRITE && bleft > 0) begin_wel();
          else finish_op(ST_OK);
        end else begin
          put(K_KICK, 8'h00, ST_OK);
          if (elap < tmo) begin
            ph = PH_BZ_CMD;
            put(K_SEND, CMD_RDSR, ST_OK);
          end else finish_op(ST_TIMEOUT);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flash_request(logic [2:0] f, logic [23:0] a, logic [24:0] l);
    if (f == F_PROBE) begin
      cop = F_PROBE;
      idbad = 1'b0;
      ph = PH_ID;
      bidx = '0;
      put(K_SEND, CMD_JEDEC, ST_OK);
    end else if (!rdy) finish_op(ST_NRDY);
    else if ((f == F_READ || f == F_WRITE) && l == 0) finish_op(ST_BADARG);
    else if (f == F_ESEC && a[SECTOR_BITS-1:0] != 0) finish_op(ST_BADARG);
    else if (f == F_EBLK && a[BLOCK_BITS-1:0] != 0) finish_op(ST_BADARG);
    else begin
      cop = f;
      caddr = a;
      bleft = l;
      cleft = '0;
      if (f == F_READ) begin_header(CMD_READ);
      else begin_wel();
    end
  endfunction

  // works out the results of one accepted event into step_q
  function automatic void sequence_flash_event(logic [2:0] f, logic [23:0] a,
                                               logic [24:0] l, logic [7:0] b);
    step_q.delete();
    if (f <= F_EBLK) begin
      if (ph == PH_IDLE) flash_request(f, a, l);
    end else if (f == F_HOST) begin
      if (ph == PH_HOSTW) begin
        ph = PH_PDATA;
        put(K_SEND, b, ST_OK);
      end
    end else if (f == F_REPLY) begin
      serial_reply(b);
    end else if ((ph == PH_BZ_CMD || ph == PH_BZ_DATA) && elap != 16'hFFFF) begin
      elap++;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(logic [2:0] f, logic [23:0] a, logic [24:0] l, logic [7:0] b,
                           bit gaps);
    int n;
    @(negedge clk);
    if (gaps && !calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(4, 1);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, b, l, a, f};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sequence_flash_event(f, a, l, b);
    foreach (step_q[i]) flash_results_q.push_back(step_q[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (flash_results_q.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tmo = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random event, mostly what the current phase is waiting for
  task automatic random_event();
    logic [2:0]  f;
    logic [23:0] a;
    logic [24:0] l;
    logic [7:0]  b;
    int r;
    f = 3'($urandom_range(7));
    a = 24'($urandom);
    l = 25'($urandom);
    b = 8'($urandom);
    r = $urandom_range(99);
    if (ph == PH_IDLE) begin
      if (!rdy || r < 12) f = F_PROBE;
      else if (r < 35) f = F_READ;
      else if (r < 65) f = F_WRITE;
      else if (r < 80) f = F_ESEC;
      else if (r < 92) f = F_EBLK;
      if (f == F_READ)
        l = 25'(($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(8));
      if (f == F_WRITE) begin
        l = 25'(($urandom_range(7) == 0) ? $urandom_range(600) : $urandom_range(12));
        if ($urandom_range(1)) a[7:0] = 8'hFF - 8'($urandom_range(6));
      end
      if ((f == F_ESEC || f == F_EBLK) && $urandom_range(9) != 0) a[15:0] = 16'h0;
    end else if (r >= 8) begin
      if (ph == PH_HOSTW) f = F_HOST;
      else if ((ph == PH_BZ_CMD || ph == PH_BZ_DATA) && r < 40) f = F_TICK;
      else begin
        f = F_REPLY;
        if (ph == PH_ID && $urandom_range(19) != 0)
          b = (bidx == 1) ? ID0 : (bidx == 2) ? ID1 : ID2;
        if (ph == PH_RS_DATA && $urandom_range(9) != 0) b[1] = 1'b1;
        if (ph == PH_BZ_DATA) b[0] = ($urandom_range(99) < 40);
      end
    end
    send_item(f, a, l, b, 1'b1);
  endtask

  stim_row_t rows[] = '{
    '{F_READ,  24'h0, 25'd1, 8'h00, 1, K_DONE, ST_NRDY},
    '{F_WRITE, 24'hFFFFFF, 25'd1, 8'h00, 1, K_DONE, ST_NRDY},
    '{F_ESEC,  24'h0, 25'd0, 8'h00, 1, K_DONE, ST_NRDY},
    '{F_EBLK,  24'h0, 25'd0, 8'h00, 1, K_DONE, ST_NRDY},
    '{F_TICK,  24'h0, 25'd0, 8'h00, 0, K_DONE, ST_OK},
    '{F_HOST,  24'h0, 25'd0, 8'hFF, 0, K_DONE, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'hFF, 0, K_DONE, ST_OK},
    '{F_PROBE, 24'h0, 25'd0, 8'h00, 1, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h40, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h18, 1, K_DONE, ST_IDBAD},
    '{F_PROBE, 24'h0, 25'd0, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'hFF, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'hEF, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h40, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h18, 1, K_DONE, ST_OK},
    '{F_READ,  24'h0, 25'd0, 8'h00, 1, K_DONE, ST_BADARG},
    '{F_ESEC,  24'h000800, 25'd0, 8'h00, 1, K_DONE, ST_BADARG},
    '{F_EBLK,  24'h001000, 25'd0, 8'h00, 1, K_DONE, ST_BADARG},
    '{F_READ,  24'hFFFFFF, 25'd1, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'h00, 0, K_SEND, ST_OK},
    '{F_REPLY, 24'h0, 25'd0, 8'hA5, 1, K_DONE, ST_OK}
  };

  logic [15:0] timeouts[6] = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd5000};

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    ph = PH_IDLE;
    cop = '0;
    rdy = 1'b0;
    caddr = '0;
    bleft = '0;
    cleft = '0;
    bidx = '0;
    elap = '0;
    idbad = 1'b0;
    tmo = TIMEOUT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_item(rows[i].f, rows[i].a, rows[i].l, rows[i].b, 1'b0);
      if (rows[i].chk && (step_q.size() == 0 ||
          step_q[step_q.size()-1].kind != rows[i].kind ||
          step_q[step_q.size()-1].st != rows[i].st))
        report($sformatf("table row %0d final result differs", i));
    end

    // random part at the reset timeout first, then every other setting
    for (int i = 0; i < 110; i++) random_event();
    foreach (timeouts[t]) begin
      wait_drained();
      write_timeout(timeouts[t]);
      for (int i = 0; i < 45; i++) begin
        calm = (t == 3);
        random_event();
      end
      calm = 0;
    end
    wait_drained();
    if (errors == 0) $display("PASS spi_nor_flash_command_sequencer");
    else $display("FAIL spi_nor_flash_command_sequencer");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    flash_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (flash_results_q.size() == 0) begin
        report($sformatf("unexpected result %h last %b", m_tdata, m_tlast));
      end else begin
        want = flash_results_q.pop_front();
        if (m_tdata[2:0] != want.kind)
          report($sformatf("kind %0d, want %0d", m_tdata[2:0], want.kind));
        if (m_tdata[10:3] != want.ob)
          report($sformatf("byte %h, want %h", m_tdata[10:3], want.ob));
        if (m_tdata[13:11] != want.st)
          report($sformatf("status %0d, want %0d", m_tdata[13:11], want.st));
        if (m_tlast != want.last)
          report($sformatf("last %b, want %b", m_tlast, want.last));
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cnt <= 0;
    else if (idle_cnt >= STALL_LIMIT) begin
      $display("FAIL spi_nor_flash_command_sequencer");
      $finish;
    end else idle_cnt <= idle_cnt + 1;
  end

endmodule

/* sim.f */
+incdir+sv
sv/snfcs_pkg.sv
sv/spi_nor_flash_command_sequencer.sv
sim/spi_nor_flash_command_sequencer_test.sv
